// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion macros used by the SHA-1 checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the active-low reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication under the active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// ----- rtl/core/sha1_pkg.sv -----
// Types and constants for the SHA-1 message digest block
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef logic [0:4][31:0] t_chain;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       start;
        logic       reinit;
    } t_core_ctrl;

    typedef struct packed {
        logic done;
    } t_core_stat;

    localparam t_chain H_INIT = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [5:0] FILL_LEN      = 6'd56;
    localparam logic [3:0] LEN_BYTES     = 4'd8;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

endpackage

// ----- rtl/core/sha1_compress.sv -----
// SHA-1 block window, round unit, sequencer and chain value
module sha1_compress (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha1_pkg::t_core_ctrl i_ctrl,
    output sha1_pkg::t_core_stat o_stat,
    output sha1_pkg::t_chain     o_chain
);
    import sha1_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } t_cstate;

    t_cstate      r_state;
    logic [6:0]   r_round;
    logic         r_done;
    t_chain       r_chain;
    t_chain       r_work;
    logic [511:0] r_window;

    logic [31:0] w_cur;
    logic [31:0] w_mix;
    logic [31:0] w_next;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    t_chain      n_work;

    assign w_cur  = r_window[511:480];
    assign w_mix  = r_window[95:64] ^ r_window[255:224]
                  ^ r_window[447:416] ^ r_window[511:480];
    assign w_next = {w_mix[30:0], w_mix[31]};

    always_comb begin
        case (r_round) inside
            [7'd0:7'd19]: begin
                f_val = (r_work[1] & r_work[2]) | (~r_work[1] & r_work[3]);
                k_val = K_ROUND0;
            end
            [7'd20:7'd39]: begin
                f_val = r_work[1] ^ r_work[2] ^ r_work[3];
                k_val = K_ROUND1;
            end
            [7'd40:7'd59]: begin
                f_val = (r_work[1] & r_work[2]) | (r_work[1] & r_work[3])
                      | (r_work[2] & r_work[3]);
                k_val = K_ROUND2;
            end
            default: begin
                f_val = r_work[1] ^ r_work[2] ^ r_work[3];
                k_val = K_ROUND3;
            end
        endcase
        t_val = {r_work[0][26:0], r_work[0][31:27]} + f_val + r_work[4] + k_val + w_cur;
        n_work[0] = t_val;
        n_work[1] = r_work[0];
        n_work[2] = {r_work[1][1:0], r_work[1][31:2]};
        n_work[3] = r_work[2];
        n_work[4] = r_work[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
            r_chain <= H_INIT;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_ctrl.reinit) begin
                        r_chain <= H_INIT;
                    end
                    if (i_ctrl.start) begin
                        r_round <= '0;
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    if (r_round == LAST_ROUND) begin
                        r_round <= '0;
                        r_state <= C_ADD;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                C_ADD: begin
                    for (int i = 0; i < 5; i++) begin
                        r_chain[i] <= r_chain[i] + r_work[i];
                    end
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_ROUND) begin
            r_work   <= n_work;
            r_window <= {r_window[479:0], w_next};
        end else begin
            if (i_ctrl.start) begin
                r_work <= r_chain;
            end
            if (i_ctrl.shift_byte) begin
                r_window <= {r_window[503:0], i_ctrl.byte_val};
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_chain     = r_chain;

endmodule

// ----- rtl/core/sha1_message_digest.sv -----
// SHA-1 message digest top level: byte intake, padding, digest output
//
// Takes one item per cycle while o_in_stall is low; each item carries at most one message
// byte. When a 64-byte block fills, the block stalls its input while it runs 80 SHA-1 rounds
// at one per cycle through a single round adder, folds the result into the chain value and
// hands back. On an end-of-message item the block inserts its own padding and length bytes
// (9 to 72) at one byte per cycle, except while a filled block compresses, runs one or two
// more compressions, then presents five digest words, most significant first, each held until
// taken. The chain value returns to the SHA-1 initial value once the fifth word is taken.
module sha1_message_digest (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sha1_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sha1_pkg::t_out_item o_out_item
);
    import sha1_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_msg_bits;
    logic        r_closing;
    logic        r_mark_done;
    logic [3:0]  r_len_cnt;
    logic [2:0]  r_out_idx;

    logic       in_acc;
    logic       ins_en;
    logic [7:0] ins_byte;
    logic       len_phase;
    logic       fill_wrap;
    t_core_ctrl core_ctrl;
    t_core_stat core_stat;
    t_chain     chain;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign len_phase  = r_mark_done && ((r_len_cnt != 4'd0) || (r_fill == FILL_LEN));

    always_comb begin
        ins_en   = 1'b0;
        ins_byte = i_in_item.data_byte;
        if (r_state == ST_IDLE) begin
            ins_en = in_acc && i_in_item.has_byte;
        end else if (r_state == ST_PAD) begin
            ins_en = 1'b1;
            if (!r_mark_done) begin
                ins_byte = PAD_MARK;
            end else if (len_phase) begin
                ins_byte = r_msg_bits[63:56];
            end else begin
                ins_byte = 8'h00;
            end
        end
    end

    assign fill_wrap = ins_en && (r_fill == FILL_LAST);

    always_comb begin
        core_ctrl.shift_byte = ins_en;
        core_ctrl.byte_val   = ins_byte;
        core_ctrl.start      = fill_wrap;
        core_ctrl.reinit     = (r_state == ST_OUT) && !i_out_stall
                            && (r_out_idx == LAST_WORD_IDX);
    end

    sha1_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (core_ctrl),
        .o_stat  (core_stat),
        .o_chain (chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_msg_bits  <= '0;
            r_closing   <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_cnt   <= '0;
            r_out_idx   <= '0;
        end else begin
            if (ins_en) begin
                r_fill <= r_fill + 6'd1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in_item.has_byte) begin
                            r_msg_bits <= r_msg_bits + BITS_PER_BYTE;
                        end
                        if (i_in_item.end_of_message) begin
                            r_closing   <= 1'b1;
                            r_mark_done <= 1'b0;
                            r_len_cnt   <= '0;
                        end
                        if (fill_wrap) begin
                            r_state <= ST_COMP;
                        end else if (i_in_item.end_of_message) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    if (!r_mark_done) begin
                        r_mark_done <= 1'b1;
                    end else if (len_phase) begin
                        r_msg_bits <= {r_msg_bits[55:0], 8'h00};
                        r_len_cnt  <= r_len_cnt + 4'd1;
                    end
                    if (fill_wrap) begin
                        r_state <= ST_COMP;
                    end
                end
                ST_COMP: begin
                    if (core_stat.done) begin
                        if (r_closing && (r_len_cnt == LEN_BYTES)) begin
                            r_out_idx <= '0;
                            r_state   <= ST_OUT;
                        end else if (r_closing) begin
                            r_state <= ST_PAD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        if (r_out_idx == LAST_WORD_IDX) begin
                            r_closing  <= 1'b0;
                            r_msg_bits <= '0;
                            r_fill     <= '0;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_out_idx <= r_out_idx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid            = (r_state == ST_OUT);
    assign o_out_item.digest_word = chain[r_out_idx];
    assign o_out_item.word_index  = r_out_idx;
    assign o_out_item.last_word   = (r_out_idx == LAST_WORD_IDX);

endmodule

// ----- rtl/core/sha1_checker.sv -----
// Port-level checker for the SHA-1 message digest block, with its bind
`include "assert_macros.svh"

module sha1_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input sha1_pkg::t_out_item o_out_item
);
    import sha1_pkg::*;

    logic last_acc;
    logic idx_ok;

    assign last_acc = o_out_valid && !i_out_stall && o_out_item.last_word;
    assign idx_ok   = (o_out_item.word_index <= LAST_WORD_IDX)
                   && (o_out_item.last_word == (o_out_item.word_index == LAST_WORD_IDX));

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_item))
    `ASSERT_NOW(a_idx_ok, i_clk, i_rst_n, o_out_valid, idx_ok)
    `ASSERT_NOW(a_no_intake_during_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, last_acc, !o_out_valid && !o_in_stall)

endmodule

bind sha1_message_digest sha1_checker u_checker (.*);
